/* rtl/gtbs_pkg.sv */
// Glyph table binary search: shared constants.
// No dependencies; imported by every other file of the block except gtbs_ram.
package gtbs_pkg;

	localparam int COUNT_W   = 8;
	localparam int CNT_W     = COUNT_W + 1;
	localparam int INDEX_W   = 8;
	localparam int CODE_W    = 8;
	localparam int WIDTH_W   = 8;
	localparam int OFFSET_W  = 16;
	localparam int WORD_W    = CODE_W + WIDTH_W + OFFSET_W;
	localparam int CODE_LSB  = WIDTH_W + OFFSET_W;
	localparam int WIDTH_LSB = OFFSET_W;

	localparam int TABLE_DEPTH_DEF = 256;

	localparam logic CMD_LOAD   = 1'b0;
	localparam logic CMD_LOOKUP = 1'b1;

endpackage

/* rtl/gtbs_if.sv */
// Glyph table binary search: request and response channel interfaces.
// Depends on gtbs_pkg for field widths.
interface gtbs_req_if import gtbs_pkg::*;;
	logic                valid;
	logic                ready;
	logic                cmd;
	logic [INDEX_W-1:0]  entry_index;
	logic [CODE_W-1:0]   entry_code;
	logic [WIDTH_W-1:0]  entry_width;
	logic [OFFSET_W-1:0] entry_offset;
	logic [CODE_W-1:0]   query_char;

	modport source (output valid, cmd, entry_index, entry_code, entry_width, entry_offset,
		query_char, input ready);
	modport sink (input valid, cmd, entry_index, entry_code, entry_width, entry_offset,
		query_char, output ready);
endinterface

interface gtbs_rsp_if import gtbs_pkg::*;;
	logic                valid;
	logic                ready;
	logic                found;
	logic [WIDTH_W-1:0]  glyph_width;
	logic [OFFSET_W-1:0] data_offset;

	modport source (output valid, found, glyph_width, data_offset, input ready);
	modport sink (input valid, found, glyph_width, data_offset, output ready);
endinterface

/* rtl/gtbs_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module gtbs_ram #(
	parameter int W = 32,
	parameter int D = 256,
	localparam int AW = $clog2(D)
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [W-1:0]  wdata,
	input  logic          re,
	input  logic [AW-1:0] raddr,
	output logic [W-1:0]  rdata
);

	logic [W-1:0] mem [D];
	logic [W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

/* rtl/gtbs_cell.sv */
// Glyph table binary search: one probe cell, deciding one index bit.
// Depends on gtbs_pkg; receives the table code read for its candidate index.
module gtbs_cell import gtbs_pkg::*; #(
	parameter int AW  = 8,
	parameter int BIT = 0
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_v,
	input  logic [AW-1:0]     in_idx,
	input  logic [CODE_W-1:0] in_q,
	input  logic [CNT_W-1:0]  cnt,
	input  logic [CODE_W-1:0] rd_code,
	output logic              out_v,
	output logic [AW-1:0]     out_idx,
	output logic [CODE_W-1:0] out_q,
	output logic              rd_re,
	output logic [AW-1:0]     rd_addr
);

	localparam int NB = (BIT > 0) ? BIT - 1 : 0;
	localparam logic [AW-1:0] CUR_BIT  = AW'(1) << BIT;
	localparam logic [AW-1:0] NEXT_BIT = (BIT > 0) ? (AW'(1) << NB) : '0;

	logic              reject;
	logic [AW-1:0]     idx_dec;
	logic [AW-1:0]     nxt;
	logic              v_q;
	logic [AW-1:0]     idx_q;
	logic [CODE_W-1:0] q_q;

	always_comb begin
		reject  = (CNT_W'(in_idx) >= cnt) || (rd_code > in_q);
		idx_dec = reject ? (in_idx & ~CUR_BIT) : in_idx;
		nxt     = idx_dec | NEXT_BIT;
		rd_re   = in_v;
		rd_addr = in_v ? nxt : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= 1'b0;
		end else begin
			v_q <= in_v;
		end
	end

	always_ff @(posedge clk) begin
		if (in_v) begin
			idx_q <= nxt;
			q_q   <= in_q;
		end
	end

	assign out_v   = v_q;
	assign out_idx = idx_q;
	assign out_q   = q_q;

endmodule

/* rtl/gtbs_match.sv */
// Glyph table binary search: final match cell with result holding and output register.
// Depends on gtbs_pkg and gtbs_rsp_if; receives the table word of the final index.
module gtbs_match import gtbs_pkg::*; #(
	parameter int AW = 8
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              tok_v,
	input  logic [AW-1:0]     tok_idx,
	input  logic [CODE_W-1:0] tok_q,
	input  logic [CNT_W-1:0]  cnt,
	input  logic [WORD_W-1:0] rd_word,
	output logic              res_pend,
	gtbs_rsp_if.source        rsp
);

	logic                hit;
	logic [WIDTH_W-1:0]  hit_width;
	logic [OFFSET_W-1:0] hit_offset;
	logic                out_free;
	logic                res_v_q;
	logic                res_found_q;
	logic [WIDTH_W-1:0]  res_width_q;
	logic [OFFSET_W-1:0] res_offset_q;
	logic                out_v_q;
	logic                out_found_q;
	logic [WIDTH_W-1:0]  out_width_q;
	logic [OFFSET_W-1:0] out_offset_q;

	always_comb begin
		hit = (CNT_W'(tok_idx) < cnt) &&
			(rd_word[CODE_LSB +: CODE_W] == tok_q);
		hit_width  = hit ? rd_word[WIDTH_LSB +: WIDTH_W] : '0;
		hit_offset = hit ? rd_word[OFFSET_W-1:0] : '0;
		out_free   = !out_v_q || rsp.ready;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_v_q <= 1'b0;
			out_v_q <= 1'b0;
		end else begin
			if (tok_v) begin
				res_v_q <= !out_free;
				if (out_free) begin
					out_v_q <= 1'b1;
				end
			end else if (res_v_q && out_free) begin
				res_v_q <= 1'b0;
				out_v_q <= 1'b1;
			end else if (rsp.ready) begin
				out_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (tok_v && !out_free) begin
			res_found_q  <= hit;
			res_width_q  <= hit_width;
			res_offset_q <= hit_offset;
		end
		if (tok_v && out_free) begin
			out_found_q  <= hit;
			out_width_q  <= hit_width;
			out_offset_q <= hit_offset;
		end else if (res_v_q && out_free) begin
			out_found_q  <= res_found_q;
			out_width_q  <= res_width_q;
			out_offset_q <= res_offset_q;
		end
	end

	assign res_pend         = res_v_q;
	assign rsp.valid        = out_v_q;
	assign rsp.found        = out_found_q;
	assign rsp.glyph_width  = out_width_q;
	assign rsp.data_offset  = out_offset_q;

endmodule

/* rtl/glyph_table_binary_search.sv */
// Glyph table binary search: top level with table RAM, probe cell chain and match cell.
// Depends on gtbs_pkg, gtbs_if, gtbs_ram, gtbs_cell and gtbs_match.
//
// A load transaction (cmd 0) writes one table slot and gives no response.
// A lookup transaction (cmd 1) walks a chain of log2(TABLE_DEPTH) probe cells, one index bit
// per cell from the top bit down, each cell getting one word from the table RAM's single read
// port; the match cell then checks the slot reached. With the output register free, the
// response passes from the entry register through each probe cell to the output register, and
// the next transaction is accepted only once the lookup has left the cell chain. A response
// not yet taken waits in the output register while further transactions are accepted; a second
// finished response waits in the match cell and holds the input off until the output register
// frees. The user must write glyph_count only while no lookup is in flight; the block itself
// does not enforce this; slots must be written before use.
module glyph_table_binary_search import gtbs_pkg::*; #(
	parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [COUNT_W-1:0] cfg_wdata,
	gtbs_req_if.sink           req,
	gtbs_rsp_if.source         rsp
);

	localparam int AW = $clog2(TABLE_DEPTH);
	localparam logic [AW-1:0]    TOP_BIT = AW'(1) << (AW - 1);
	localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(TABLE_DEPTH);

	logic [COUNT_W-1:0] glyph_count_q;
	logic [CNT_W-1:0]   cnt;
	logic               acc;
	logic               lookup_acc;
	logic               ram_we;
	logic               ram_re;
	logic [AW-1:0]      ram_raddr;
	logic [WORD_W-1:0]  ram_rdata;
	logic               res_pend;

	logic [AW:0]         stg_v;
	logic [AW-1:0]       stg_idx [AW+1];
	logic [CODE_W-1:0]   stg_q [AW+1];
	logic [AW-1:0]       cell_re;
	logic [AW-1:0]       cell_addr [AW];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			glyph_count_q <= '0;
		end else if (cfg_we) begin
			glyph_count_q <= cfg_wdata;
		end
	end

	always_comb begin
		cnt = (CNT_W'(glyph_count_q) > DEPTH_C) ? DEPTH_C : CNT_W'(glyph_count_q);
	end

	assign req.ready  = !(|stg_v) && !res_pend;
	assign acc        = req.valid && req.ready;
	assign lookup_acc = acc && (req.cmd == CMD_LOOKUP);
	assign ram_we     = acc && (req.cmd == CMD_LOAD) && (CNT_W'(req.entry_index) < DEPTH_C);

	always_comb begin
		ram_re    = lookup_acc;
		ram_raddr = lookup_acc ? TOP_BIT : '0;
		for (int k = 0; k < AW; k++) begin
			ram_re    = ram_re | cell_re[k];
			ram_raddr = ram_raddr | cell_addr[k];
		end
	end

	gtbs_ram #(
		.W (WORD_W),
		.D (TABLE_DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (req.entry_index[AW-1:0]),
		.wdata ({req.entry_code, req.entry_width, req.entry_offset}),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stg_v[0] <= 1'b0;
		end else begin
			stg_v[0] <= lookup_acc;
		end
	end

	always_ff @(posedge clk) begin
		if (lookup_acc) begin
			stg_idx[0] <= TOP_BIT;
			stg_q[0]   <= req.query_char;
		end
	end

	for (genvar k = 0; k < AW; k++) begin : g_cell
		gtbs_cell #(
			.AW  (AW),
			.BIT (AW - 1 - k)
		) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.in_v    (stg_v[k]),
			.in_idx  (stg_idx[k]),
			.in_q    (stg_q[k]),
			.cnt     (cnt),
			.rd_code (ram_rdata[CODE_LSB +: CODE_W]),
			.out_v   (stg_v[k+1]),
			.out_idx (stg_idx[k+1]),
			.out_q   (stg_q[k+1]),
			.rd_re   (cell_re[k]),
			.rd_addr (cell_addr[k])
		);
	end

	gtbs_match #(
		.AW (AW)
	) u_match (
		.clk      (clk),
		.arst_n   (arst_n),
		.tok_v    (stg_v[AW]),
		.tok_idx  (stg_idx[AW]),
		.tok_q    (stg_q[AW]),
		.cnt      (cnt),
		.rd_word  (ram_rdata),
		.res_pend (res_pend),
		.rsp      (rsp)
	);

	a_one_token: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({stg_v, res_pend}))
		else $error("more than one lookup in flight");

	a_rw_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(ram_we && ram_re))
		else $error("table write and read in the same cycle");

	a_enter: assert property (@(posedge clk) disable iff (!arst_n)
		lookup_acc |=> stg_v[0])
		else $error("accepted lookup did not enter the cell chain");

	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && !rsp.found) |-> (rsp.glyph_width == '0 && rsp.data_offset == '0))
		else $error("miss response carries nonzero fields");

	a_count_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(|stg_v) |-> !cfg_we)
		else $error("glyph_count written during a lookup");

endmodule
